### rtl/core/mcg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table of the metronome click generator.
// No dependencies; every other file of the block imports this package.
package mcg_pkg;

	// Stream field widths
	localparam int SMP_W        = 16;
	localparam int CMD_W        = 2;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 72;
	localparam int TOTAL_W      = 32;
	localparam int BARPOS_W     = 4;

	// Configuration port
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 30;
	localparam int SPB_W        = 30;
	localparam int BPB_CFG_W    = 5;
	localparam int INC_W        = 23;
	localparam int DECAY_W      = 18;
	localparam int GAIN_W       = 16;

	// Beat timing
	localparam int CD_W          = 32;
	localparam int ONE_SAMPLE    = 256;
	localparam int MAX_BAR_BEATS = 16;
	localparam int BAR_W         = $clog2(MAX_BAR_BEATS);
	localparam int BPB_W         = BAR_W + 1;

	// Click synthesis
	localparam int PHASE_W     = 24;
	localparam int ENV_W       = 19;
	localparam int ENV_FRAC    = 18;
	localparam int GAIN_FRAC   = 15;
	localparam logic [ENV_W-1:0] ENV_ONE   = ENV_W'(262144);
	localparam logic [ENV_W-1:0] ENV_FLOOR = ENV_W'(26);
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_AW     = $clog2(SINE_DEPTH);
	localparam int SINE_MAG_W  = 15;
	localparam int CLICK_W     = 17;
	localparam logic [SINE_MAG_W-1:0] SINE_PEAK = '1;

	// Digit-serial multiplier
	localparam int MUL_AW     = 19;
	localparam int MUL_DIG    = 4;
	localparam int MUL_DIGITS = (MUL_AW + MUL_DIG - 1) / MUL_DIG;
	localparam int MUL_BW     = MUL_DIGITS * MUL_DIG;
	localparam int MUL_PW     = 2 * MUL_AW;
	localparam int MUL_CW     = $clog2(MUL_DIGITS + 1);

	// Table generation, Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam longint      Q30_ONE     = 64'sd1073741824;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPB     = 3'd0,
		CFG_BPB     = 3'd1,
		CFG_ACC_INC = 3'd2,
		CFG_NRM_INC = 3'd3,
		CFG_DECAY   = 3'd4,
		CFG_GAIN    = 3'd5,
		CFG_AUDIBLE = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINE,
		ST_ENV,
		ST_GAIN,
		ST_DECAY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_AW-1:0] b;
	} mul_req_t;

	typedef logic [15:0] sine_rom_t [SINE_DEPTH];

	// round(32767 * sin(pi/2 * i / depth)) by a truncating Q30 Taylor series
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] r;
		longint      s;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			x    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
			term = x;
			s    = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				term = (((term * x) >> 30) * x) >> 30;
				case (k)
					1:       term = term / 64'd6;
					2:       term = term / 64'd20;
					3:       term = term / 64'd42;
					4:       term = term / 64'd72;
					5:       term = term / 64'd110;
					default: term = term / 64'd156;
				endcase
				if ((k & 1) != 0) s = s - longint'(term);
				else s = s + longint'(term);
			end
			if (s < 0) s = 0;
			if (s > Q30_ONE) s = Q30_ONE;
			r = ((64'(s) * 64'd32767) + (64'd1 << 29)) >> 30;
			rom[i] = r[15:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### rtl/core/mcg_smul.sv
`timescale 1ns / 1ps
// Digit-serial unsigned multiplier: one 4-bit digit of b per cycle, most significant first.
// Depends on mcg_pkg for widths and the request struct.
module mcg_smul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcg_pkg::mul_req_t             req,
	output logic [mcg_pkg::MUL_PW-1:0]    prod,
	output logic                          done
);
	import mcg_pkg::*;

	localparam int PP_W = MUL_AW + MUL_DIG;

	logic [MUL_CW-1:0] cnt_q;
	logic              done_q;
	logic [MUL_AW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [MUL_PW-1:0] acc_q;
	logic [MUL_DIG-1:0] digit;
	logic [PP_W-1:0]   pp;
	logic [MUL_PW-1:0] acc_next;

	assign digit    = b_q[MUL_BW-1 -: MUL_DIG];
	assign pp       = PP_W'(a_q) * PP_W'(digit);
	assign acc_next = (acc_q << MUL_DIG) + MUL_PW'(pp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= MUL_CW'(MUL_DIGITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= MUL_BW'(req.b);
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= acc_next;
			b_q   <= b_q << MUL_DIG;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

### rtl/core/mcg_sine.sv
`timescale 1ns / 1ps
// Phase to sine lookup: quadrant fold onto the quarter-wave table, registered read.
// Depends on mcg_pkg for the table contents and widths.
module mcg_sine (
	input  logic                             clk,
	input  logic                             load,
	input  logic [mcg_pkg::PHASE_W-1:0]      phase,
	output logic [mcg_pkg::SINE_MAG_W-1:0]   mag,
	output logic                             neg
);
	import mcg_pkg::*;

	logic [SINE_AW-1:0]    idx;
	logic [SINE_AW-1:0]    addr;
	logic                  mirror;
	logic                  peak;
	logic [SINE_MAG_W-1:0] mag_q;
	logic                  neg_q;

	assign mirror = phase[PHASE_W-2];
	assign idx    = phase[PHASE_W-3 -: SINE_AW];
	// falling quadrants read the table backwards; index zero there is the crest
	assign addr   = mirror ? (SINE_AW'(0) - idx) : idx;
	assign peak   = mirror && (idx == '0);

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= peak ? SINE_PEAK : SINE_ROM[addr][SINE_MAG_W-1:0];
			neg_q <= phase[PHASE_W-1];
		end
	end

	assign mag = mag_q;
	assign neg = neg_q;

endmodule

### rtl/core/mcg_barmod.sv
`timescale 1ns / 1ps
// Bit-serial remainder for the next bar beat: (bar beat + 1) mod beats per bar.
// Depends on mcg_pkg for widths.
module mcg_barmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mcg_pkg::BPB_W-1:0]   num,
	input  logic [mcg_pkg::BPB_W-1:0]   den,
	output logic                        busy,
	output logic                        done,
	output logic [mcg_pkg::BAR_W-1:0]   res
);
	import mcg_pkg::*;

	localparam int CNT_W = $clog2(BPB_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [BPB_W-1:0] rem_q;
	logic [BPB_W-1:0] num_q;
	logic [BPB_W-1:0] den_q;
	logic [BPB_W:0]   r_sh;
	logic [BPB_W:0]   r_nx;

	// restoring step: bring down one numerator bit, subtract when it fits
	assign r_sh = {rem_q, num_q[BPB_W-1]};
	assign r_nx = (r_sh >= {1'b0, den_q}) ? (r_sh - {1'b0, den_q}) : r_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(BPB_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= r_nx[BPB_W-1:0];
			num_q <= num_q << 1;
		end
	end

	assign busy = (cnt_q != '0) || done_q;
	assign done = done_q;
	assign res  = rem_q[BAR_W-1:0];

endmodule

### rtl/core/metronome_click_generator_top.sv
`timescale 1ns / 1ps
// Metronome click generator top level: config registers, beat counter, sequencer, output stage.
// Depends on mcg_pkg, mcg_smul, mcg_sine and mcg_barmod.
//
// One stream item in, one out. s_tuser carries the command (tick, start, stop) and s_tdata the
// stereo sample. A start, a stop and a tick while stopped go straight to the done state and
// reach the output register once it is free. A tick while running goes from acceptance
// through the table read, three passes through the shared 4-bit serial multiplier (sine
// times envelope, times gain, envelope times decay) and the load of the output register.
// The input side is ready again as soon as the result is in the output register, so a
// stalled consumer costs nothing until the next result is due. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no item is in flight, as the
// block itself does not enforce it; the sine table is constant and needs no fill after reset.
module metronome_click_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [mcg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcg_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mcg_pkg::IN_TDATA_W-1:0]    s_tdata,   // left_in[15:0], right_in[31:16]
	input  logic [mcg_pkg::CMD_W-1:0]         s_tuser,   // command[1:0]
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mcg_pkg::OUT_TDATA_W-1:0]   m_tdata    // left_out[15:0], right_out[31:16],
	                                                     // beat_start[32], accent[33],
	                                                     // bar_position[37:34],
	                                                     // beats_so_far[69:38], zero [71:70]
);
	import mcg_pkg::*;

	// configuration registers
	logic [SPB_W-1:0]     spb_q;
	logic [BPB_CFG_W-1:0] bpb_q;
	logic [INC_W-1:0]     acc_inc_q;
	logic [INC_W-1:0]     nrm_inc_q;
	logic [DECAY_W-1:0]   decay_q;
	logic [GAIN_W-1:0]    gain_q;
	logic                 audible_q;

	// metronome state
	state_t               state_q, state_d;
	logic                 running_q;
	logic signed [CD_W-1:0] cd_q;
	logic [BAR_W-1:0]     bar_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [PHASE_W-1:0]   step_q;
	logic [ENV_W-1:0]     env_q;

	// per-item registers
	logic signed [SMP_W-1:0] left_q, right_q;
	logic                 add_click_q;
	logic                 trig_q;
	logic                 accent_q;
	logic [CLICK_W-1:0]   click_q;

	// output stage
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// combinational
	logic                 s_accept;
	cmd_t                 cmd;
	logic                 tick_run;
	logic                 trig;
	logic                 accent;
	logic [SPB_W-1:0]     spb_eff;
	logic [BPB_W-1:0]     bpb_eff;
	logic [PHASE_W-1:0]   phase_post;
	logic [PHASE_W-1:0]   step_post;
	logic [ENV_W-1:0]     env_post;
	logic signed [CD_W-1:0] cd_post;
	logic                 out_load;
	mul_req_t             mul_req;
	logic [MUL_PW-1:0]    mul_prod;
	logic                 mul_done;
	logic [SINE_MAG_W-1:0] sine_mag;
	logic                 sine_neg;
	logic                 bm_busy;
	logic                 bm_done;
	logic [BAR_W-1:0]     bm_res;
	logic signed [SMP_W+1:0] click_s;
	logic signed [SMP_W-1:0] left_sat, right_sat;

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SMP_W+1:0] v);
		logic signed [SMP_W+1:0] hi;
		logic signed [SMP_W+1:0] lo;
		hi = (SMP_W+2)'(32767);
		lo = -(SMP_W+2)'(32768);
		if (v > hi) return SMP_W'(32767);
		if (v < lo) return SMP_W'(-32768);
		return v[SMP_W-1:0];
	endfunction

	assign s_accept = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign tick_run = (cmd == CMD_TICK) && running_q;

	// beat decision from the countdown before this sample
	assign trig       = cd_q[CD_W-1] || (cd_q == '0);
	assign accent     = trig && (bar_q == '0);
	assign spb_eff    = (spb_q < SPB_W'(ONE_SAMPLE)) ? SPB_W'(ONE_SAMPLE) : spb_q;
	assign bpb_eff    = (bpb_q == '0) ? BPB_W'(1) :
	                    (int'(bpb_q) > MAX_BAR_BEATS) ? BPB_W'(MAX_BAR_BEATS) : BPB_W'(bpb_q);
	assign phase_post = trig ? '0 : phase_q;
	assign step_post  = trig ? (accent ? PHASE_W'(acc_inc_q) : PHASE_W'(nrm_inc_q)) : step_q;
	assign env_post   = trig ? ENV_ONE : env_q;
	assign cd_post    = trig ? (cd_q + CD_W'(spb_eff)) : cd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q     <= SPB_W'(5644800);
			bpb_q     <= BPB_CFG_W'(4);
			acc_inc_q <= INC_W'(609637);
			nrm_inc_q <= INC_W'(400074);
			decay_q   <= DECAY_W'(261974);
			gain_q    <= GAIN_W'(32768);
			audible_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SPB:     spb_q     <= cfg_data[SPB_W-1:0];
				CFG_BPB:     bpb_q     <= cfg_data[BPB_CFG_W-1:0];
				CFG_ACC_INC: acc_inc_q <= cfg_data[INC_W-1:0];
				CFG_NRM_INC: nrm_inc_q <= cfg_data[INC_W-1:0];
				CFG_DECAY:   decay_q   <= cfg_data[DECAY_W-1:0];
				CFG_GAIN:    gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_AUDIBLE: audible_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mcg_sine u_sine (
		.clk   (clk),
		.load  (s_accept),
		.phase (phase_post),
		.mag   (sine_mag),
		.neg   (sine_neg)
	);

	mcg_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	mcg_barmod u_barmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_accept && tick_run && trig),
		.num    (BPB_W'(bar_q) + 1'b1),
		.den    (bpb_eff),
		.busy   (bm_busy),
		.done   (bm_done),
		.res    (bm_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_accept) state_d = tick_run ? ST_SINE : ST_DONE;
			ST_SINE:  state_d = ST_ENV;
			ST_ENV:   if (mul_done) state_d = ST_GAIN;
			ST_GAIN:  if (mul_done) state_d = ST_DECAY;
			ST_DECAY: if (mul_done) state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready      = 1'b0;
		out_load      = 1'b0;
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SINE: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_AW'(sine_mag);
				mul_req.b     = MUL_AW'(env_q);
			end
			ST_ENV: begin
				mul_req.start = mul_done;
				mul_req.a     = MUL_AW'(mul_prod[ENV_FRAC+SINE_MAG_W-1:ENV_FRAC]);
				mul_req.b     = MUL_AW'(gain_q);
			end
			ST_GAIN: begin
				mul_req.start = mul_done;
				mul_req.a     = MUL_AW'(env_q);
				mul_req.b     = MUL_AW'(decay_q);
			end
			ST_DECAY: ;
			ST_DONE: begin
				out_load = !bm_busy && (!m_tvalid_q || m_tready);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
			cd_q      <= '0;
			bar_q     <= '0;
			total_q   <= '0;
			phase_q   <= '0;
			step_q    <= '0;
			env_q     <= '0;
		end else begin
			state_q <= state_d;
			if (s_accept) begin
				unique case (cmd)
					CMD_START: begin
						running_q <= 1'b1;
						cd_q      <= '0;
						bar_q     <= '0;
						total_q   <= '0;
						env_q     <= '0;
					end
					CMD_STOP: running_q <= 1'b0;
					CMD_TICK: begin
						if (running_q) begin
							cd_q    <= cd_post - CD_W'(ONE_SAMPLE);
							total_q <= total_q + TOTAL_W'(trig);
							phase_q <= phase_post + step_post;
							step_q  <= step_post;
							env_q   <= env_post;
						end
					end
					default: ;
				endcase
			end
			if (bm_done) bar_q <= bm_res;
			// decay lands once the click has used the current envelope
			if (state_q == ST_DECAY && mul_done) begin
				env_q <= mul_prod[ENV_FRAC+ENV_W-1:ENV_FRAC];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			left_q      <= (cmd == CMD_TICK) ? s_tdata[SMP_W-1:0] : '0;
			right_q     <= (cmd == CMD_TICK) ? s_tdata[2*SMP_W-1:SMP_W] : '0;
			add_click_q <= tick_run && audible_q && (env_post > ENV_FLOOR);
			trig_q      <= tick_run && trig;
			accent_q    <= tick_run && accent;
		end
		if (state_q == ST_GAIN && mul_done) begin
			click_q <= mul_prod[GAIN_FRAC+CLICK_W-1:GAIN_FRAC];
		end
	end

	assign click_s   = add_click_q ?
	                   (sine_neg ? -(SMP_W+2)'(click_q) : (SMP_W+2)'(click_q)) : '0;
	assign left_sat  = sat16((SMP_W+2)'(left_q) + click_s);
	assign right_sat = sat16((SMP_W+2)'(right_q) + click_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, total_q, BARPOS_W'(bar_q), accent_q, trig_q,
			              right_sat, left_sat};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// the block holds off new items until the current one is in the output register
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_ENV || state_q == ST_GAIN || state_q == ST_DECAY))
		else $error("multiplier finished outside a multiply step");

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_ONE)
		else $error("envelope above unity");

	a_beat_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && cmd == CMD_TICK) |=>
		(total_q == $past(total_q) || total_q == $past(total_q) + TOTAL_W'(1)))
		else $error("beat count moved by more than one on a tick");

endmodule
